// ===== sv/hsl_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
// No dependencies; imported by hsl_chan and hsl_to_rgb_converter.
`default_nettype none

package hsl_pkg;

  // Channel segment of the piecewise hue rule
  localparam logic [1:0] CH_RAMP = 2'd0;  // linear ramp between p and q
  localparam logic [1:0] CH_HIGH = 2'd1;  // flat at q
  localparam logic [1:0] CH_LOW  = 2'd2;  // flat at p

  // Register load enables for the two stages inside a channel lane
  typedef struct packed {
    logic ld_a;  // segment decode stage
    logic ld_b;  // ramp multiply stage
  } hsl_ld_t;

  // Lightness corrector factor in twentieths, by rounded sextant of hue
  function automatic logic [4:0] corr_k(input logic [2:0] idx);
    logic [4:0] k;
    case (idx)
      3'd0:    k = 5'd19;
      3'd1:    k = 5'd20;
      3'd2:    k = 5'd20;
      3'd3:    k = 5'd20;
      3'd4:    k = 5'd14;
      3'd5:    k = 5'd16;
      3'd6:    k = 5'd16;
      default: k = 5'd20;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hsl_chan.sv =====
// One color channel lane: hue segment decode, ramp multiply, byte scaling.
// Depends on hsl_pkg (segment codes, load-enable struct).
`default_nettype none

module hsl_chan
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                    clk,
  input  hsl_ld_t                ld,
  input  wire  [FRAC_BITS+2:0]   pos,    // wrapped hue position, 0 .. 6*ONE
  input  wire  [FRAC_BITS:0]     p_val,
  input  wire  [FRAC_BITS:0]     q_val,
  output logic [7:0]             chan_byte
);

  localparam int F = FRAC_BITS;
  localparam logic [F+2:0] ONE3  = (F+3)'(1) << F;
  localparam logic [F+2:0] THREE = ONE3 + (ONE3 << 1);
  localparam logic [F+2:0] FOUR  = ONE3 << 2;
  localparam logic [F:0]   ONE   = (F+1)'(1) << F;

  logic [1:0]   mode_nxt;
  logic [F:0]   frac_nxt;
  logic [F+2:0] down_pos;

  logic [1:0]   a_mode_r;
  logic [F:0]   a_frac_r;
  logic [F:0]   a_diff_r;
  logic [F:0]   a_p_r;
  logic [F:0]   a_q_r;

  logic [1:0]     b_mode_r;
  logic [2*F+1:0] b_prod_r;
  logic [F:0]     b_p_r;
  logic [F:0]     b_q_r;

  logic [F+2:0] v_sum;
  logic [F:0]   v_clip;
  logic [F+8:0] v_scaled;

  // Segment decode of the wrapped position
  always_comb begin
    down_pos = FOUR - pos;
    if (pos < ONE3) begin
      mode_nxt = CH_RAMP;
      frac_nxt = pos[F:0];
    end else if (pos < THREE) begin
      mode_nxt = CH_HIGH;
      frac_nxt = '0;
    end else if (pos < FOUR) begin
      mode_nxt = CH_RAMP;
      frac_nxt = down_pos[F:0];
    end else begin
      mode_nxt = CH_LOW;
      frac_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      a_mode_r <= mode_nxt;
      a_frac_r <= frac_nxt;
      a_diff_r <= q_val - p_val;  // q never below p
      a_p_r    <= p_val;
      a_q_r    <= q_val;
    end
  end

  // Ramp multiply
  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      b_mode_r <= a_mode_r;
      b_prod_r <= a_diff_r * a_frac_r;
      b_p_r    <= a_p_r;
      b_q_r    <= a_q_r;
    end
  end

  // Channel value, clip to one, scale by 255 and truncate
  always_comb begin
    v_sum = {2'b00, b_p_r} + {1'b0, b_prod_r[2*F+1:F]};
    case (b_mode_r)
      CH_RAMP: v_clip = (v_sum > {2'b00, ONE}) ? ONE : v_sum[F:0];
      CH_HIGH: v_clip = b_q_r;
      CH_LOW:  v_clip = b_p_r;
      default: v_clip = b_p_r;
    endcase
    v_scaled  = ({8'd0, v_clip} << 8) - {8'd0, v_clip};
    chan_byte = v_scaled[F+7:F];
  end

endmodule

`default_nettype wire

// ===== sv/hsl_to_rgb_converter.sv =====
// HSL to RGB converter: top level, nine-stage pipeline.
// Depends on hsl_pkg and hsl_chan.
//
// Usage:
//   Input channel in_valid/in_stall carries in_action, in_hue and
//   in_lightness (unsigned Q1.FRAC_BITS, values above one clamp to one).
//   Result channel out_valid/out_stall carries out_rgb_color, packed
//   red 23..16, green 15..8, blue 7..0. A transaction completes on a
//   clock edge with valid high and stall low.
//   cfg_wr_en/cfg_wr_data write the saturation register (Q1.FRAC_BITS);
//   write it only while no transaction is in flight.
// Throughput: one transaction per cycle, sustained while out_stall stays low.
// Depth: set by the lightness corrector (product, reciprocal multiply,
//   fix-up), the l*s multiply and the per-channel ramp multiply, one
//   per stage.
// Stall: each stage holds while the one after it is full and stalled;
//   empty stages keep filling, so in_stall rises only once every stage
//   holds a transaction. Nothing is dropped or repeated.
// Reset: synchronous active-low rst_n empties the pipeline and sets the
//   saturation to one half.
`default_nettype none

module hsl_to_rgb_converter
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire                   in_action,
  input  wire  [FRAC_BITS:0]    in_hue,
  input  wire  [FRAC_BITS:0]    in_lightness,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [23:0]           out_rgb_color,
  input  wire                   cfg_wr_en,
  input  wire  [FRAC_BITS:0]    cfg_wr_data
);

  localparam int F  = FRAC_BITS;
  localparam int NS = 9;
  localparam logic [F:0]   ONE   = (F+1)'(1) << F;
  localparam logic [F:0]   HALF  = (F+1)'(1) << (F-1);
  localparam logic [F+2:0] ONE3  = (F+3)'(1) << F;
  localparam logic [F+2:0] HALF3 = (F+3)'(1) << (F-1);
  localparam int unsigned  RECIP_I = (32'd1 << (F+5)) / 32'd5;
  localparam logic [F+2:0] RECIP = RECIP_I[F+2:0];

  // Stage valid and load control
  logic [NS:1] valid_r;
  logic [NS:1] ld;
  logic [NS:1] valid_in;

  assign valid_in = {valid_r[NS-1:1], in_valid};

  always_comb begin
    ld[NS] = !valid_r[NS] || !out_stall;
    for (int k = NS-1; k >= 1; k--) begin
      ld[k] = !valid_r[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = valid_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (ld[k]) valid_r[k] <= valid_in[k];
      end
    end
  end

  // Saturation register, clamped to one when written
  logic [F:0] sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= HALF;
    end else if (cfg_wr_en) begin
      sat_r <= (cfg_wr_data > ONE) ? ONE : cfg_wr_data;
    end
  end

  // Stage 1: clamp, hue times six, corrector lookup
  logic [F:0]   h_cl;
  logic [F:0]   l_cl;
  logic [F+2:0] h6_nxt;
  logic [F+2:0] idx_sum;
  logic [2:0]   idx;

  logic         s1_corr_r;
  logic [F+2:0] s1_h6_r;
  logic [F:0]   s1_l_r;
  logic [4:0]   s1_k_r;
  logic [F:0]   s1_d_r;

  always_comb begin
    h_cl    = (in_hue > ONE) ? ONE : in_hue;
    l_cl    = (in_lightness > ONE) ? ONE : in_lightness;
    h6_nxt  = ({2'b00, h_cl} << 2) + ({2'b00, h_cl} << 1);
    idx_sum = h6_nxt + HALF3;
    idx     = (idx_sum[F+2:F] > 3'd6) ? 3'd6 : idx_sum[F+2:F];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_corr_r <= in_action;
      s1_h6_r   <= h6_nxt;
      s1_l_r    <= l_cl;
      s1_k_r    <= corr_k(idx);
      s1_d_r    <= ONE - l_cl;
    end
  end

  // Stage 2: corrector product k*(1-l)
  logic [F+5:0] kd_full;
  logic         s2_corr_r;
  logic [F+2:0] s2_h6_r;
  logic [F:0]   s2_l_r;
  logic [F+4:0] s2_kd_r;

  assign kd_full = s1_k_r * s1_d_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_corr_r <= s1_corr_r;
      s2_h6_r   <= s1_h6_r;
      s2_l_r    <= s1_l_r;
      s2_kd_r   <= kd_full[F+4:0];
    end
  end

  // Stage 3: divide by 20 as (x/4)/5, reciprocal estimate
  logic [F+2:0]   y_nxt;
  logic [2*F+5:0] recip_prod;
  logic           s3_corr_r;
  logic [F+2:0]   s3_h6_r;
  logic [F:0]     s3_l_r;
  logic [F+2:0]   s3_y_r;
  logic [F:0]     s3_qt_r;

  assign y_nxt      = s2_kd_r[F+4:2];
  assign recip_prod = y_nxt * RECIP;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_corr_r <= s2_corr_r;
      s3_h6_r   <= s2_h6_r;
      s3_l_r    <= s2_l_r;
      s3_y_r    <= y_nxt;
      s3_qt_r   <= recip_prod[2*F+5:F+5];
    end
  end

  // Stage 4: quotient fix-up (estimate is low by at most one), corrected l
  logic [F+2:0] five_q;
  logic [F+2:0] rem;
  logic [F:0]   quo;
  logic [F:0]   l4_nxt;
  logic [F+2:0] s4_h6_r;
  logic [F:0]   s4_l_r;

  always_comb begin
    five_q = ({2'b00, s3_qt_r} << 2) + {2'b00, s3_qt_r};
    rem    = s3_y_r - five_q;
    quo    = s3_qt_r + ((rem >= (F+3)'(5)) ? (F+1)'(1) : (F+1)'(0));
    l4_nxt = s3_corr_r ? (ONE - quo) : s3_l_r;
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_h6_r <= s3_h6_r;
      s4_l_r  <= l4_nxt;
    end
  end

  // Stage 5: l*s
  logic [F+2:0]   s5_h6_r;
  logic [F:0]     s5_l_r;
  logic [2*F+1:0] s5_ls_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_h6_r <= s4_h6_r;
      s5_l_r  <= s4_l_r;
      s5_ls_r <= s4_l_r * sat_r;
    end
  end

  // Stage 6: q, p, grey case, wrapped channel positions
  logic [F:0]   ls_sh;
  logic [F+1:0] q_wide;
  logic [F:0]   q_nxt;
  logic [F+1:0] two_l;
  logic [F+1:0] p_diff;
  logic [F:0]   p_nxt;
  logic [F+8:0] grey_scaled;
  logic [F+2:0] pos_r_nxt;
  logic [F+2:0] pos_b_nxt;

  logic         s6_grey_r;
  logic [7:0]   s6_gbyte_r;
  logic [F:0]   s6_q_r;
  logic [F:0]   s6_p_r;
  logic [F+2:0] s6_pos_r_r;
  logic [F+2:0] s6_pos_g_r;
  logic [F+2:0] s6_pos_b_r;

  always_comb begin
    ls_sh = s5_ls_r[2*F:F];
    if (s5_l_r < HALF) begin
      q_wide = {1'b0, s5_l_r} + {1'b0, ls_sh};
    end else begin
      q_wide = {1'b0, s5_l_r} + {1'b0, sat_r} - {1'b0, ls_sh};
    end
    q_nxt       = q_wide[F:0];
    two_l       = {s5_l_r, 1'b0};
    p_diff      = two_l - {1'b0, q_nxt};
    p_nxt       = (two_l < {1'b0, q_nxt}) ? '0 : p_diff[F:0];
    grey_scaled = ({8'd0, s5_l_r} << 8) - {8'd0, s5_l_r};
    pos_r_nxt   = (s5_h6_r > (ONE3 << 2)) ? (s5_h6_r - (ONE3 << 2))
                                          : (s5_h6_r + (ONE3 << 1));
    pos_b_nxt   = (s5_h6_r < (ONE3 << 1)) ? (s5_h6_r + (ONE3 << 2))
                                          : (s5_h6_r - (ONE3 << 1));
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_grey_r  <= (sat_r == '0) || (q_nxt == '0);
      s6_gbyte_r <= grey_scaled[F+7:F];
      s6_q_r     <= q_nxt;
      s6_p_r     <= p_nxt;
      s6_pos_r_r <= pos_r_nxt;
      s6_pos_g_r <= s5_h6_r;
      s6_pos_b_r <= pos_b_nxt;
    end
  end

  // Stages 7 and 8: channel lanes; grey flag rides alongside
  hsl_ld_t    lane_ld;
  logic [7:0] red_byte;
  logic [7:0] green_byte;
  logic [7:0] blue_byte;

  logic       s7_grey_r;
  logic [7:0] s7_gbyte_r;
  logic       s8_grey_r;
  logic [7:0] s8_gbyte_r;

  assign lane_ld.ld_a = ld[7];
  assign lane_ld.ld_b = ld[8];

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
    .clk       (clk),
    .ld        (lane_ld),
    .pos       (s6_pos_r_r),
    .p_val     (s6_p_r),
    .q_val     (s6_q_r),
    .chan_byte (red_byte)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
    .clk       (clk),
    .ld        (lane_ld),
    .pos       (s6_pos_g_r),
    .p_val     (s6_p_r),
    .q_val     (s6_q_r),
    .chan_byte (green_byte)
  );

  hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
    .clk       (clk),
    .ld        (lane_ld),
    .pos       (s6_pos_b_r),
    .p_val     (s6_p_r),
    .q_val     (s6_q_r),
    .chan_byte (blue_byte)
  );

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s7_grey_r  <= s6_grey_r;
      s7_gbyte_r <= s6_gbyte_r;
    end
    if (ld[8]) begin
      s8_grey_r  <= s7_grey_r;
      s8_gbyte_r <= s7_gbyte_r;
    end
  end

  // Stage 9: output register
  logic [23:0] rgb_nxt;
  logic [23:0] out_rgb_color_r;

  assign rgb_nxt = s8_grey_r ? {s8_gbyte_r, s8_gbyte_r, s8_gbyte_r}
                             : {red_byte, green_byte, blue_byte};

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      out_rgb_color_r <= rgb_nxt;
    end
  end

  assign out_rgb_color = out_rgb_color_r;

endmodule

`default_nettype wire

// ===== tb/hsl_to_rgb_converter_tb.sv =====
// Self-checking testbench for hsl_to_rgb_converter: directed and random HSL items,
// random idling on both channels, saturation register swept between phases.
// Depends on the hsl_to_rgb_converter RTL (and hsl_pkg through it).
`default_nettype none

module hsl_to_rgb_converter_tb;

  localparam int     FRAC    = 16;
  localparam longint ONE     = longint'(1) << FRAC;
  localparam int     LATENCY = 9;
  localparam int     N_PHASE = 133;

  // Expected colors and the converter model behind them
  class rgb_scoreboard;
    logic [23:0]   pending_rgb[$];
    logic [FRAC:0] sat;
    int            errors;

    function new();
      sat    = (FRAC+1)'(1) << (FRAC - 1);
      errors = 0;
    endfunction

    function longint unit_clamp(logic [FRAC:0] raw);
      return (longint'(raw) > ONE) ? ONE : longint'(raw);
    endfunction

    // Lightness lift factor in twentieths, by rounded sextant of hue
    function longint lift_twentieths(longint idx);
      case (idx)
        0:       return 19;
        4:       return 14;
        5, 6:    return 16;
        default: return 20;
      endcase
    endfunction

    // One channel of the piecewise hue rule, t in sixths of a turn
    function logic [7:0] channel_byte(longint p, longint q, longint t);
      longint v;
      if (t < 0) t += 6 * ONE;
      if (t > 6 * ONE) t -= 6 * ONE;
      if (t < ONE)          v = p + (((q - p) * t) >>> FRAC);
      else if (t < 3 * ONE) v = q;
      else if (t < 4 * ONE) v = p + (((q - p) * (4 * ONE - t)) >>> FRAC);
      else                  v = p;
      if (v < 0) v = 0;
      if (v > ONE) v = ONE;
      return 8'((255 * v) >>> FRAC);
    endfunction

    function logic [23:0] predict_rgb(logic act, logic [FRAC:0] hue_in,
                                      logic [FRAC:0] light_in);
      longint      h, l, s, h6, q, p, idx;
      logic [7:0]  g;
      h  = unit_clamp(hue_in);
      l  = unit_clamp(light_in);
      s  = unit_clamp(sat);
      h6 = 6 * h;
      // corrected mode pulls lightness toward one
      if (act) begin
        idx = (h6 + ONE / 2) >>> FRAC;
        if (idx > 6) idx = 6;
        l = ONE - (lift_twentieths(idx) * (ONE - l)) / 20;
      end
      if (l < ONE / 2) q = (l * (s + ONE)) >>> FRAC;
      else             q = l + s - ((l * s) >>> FRAC);
      // grey: all channels from lightness alone
      if (s == 0 || q <= 0) begin
        g = 8'((255 * l) >>> FRAC);
        return {g, g, g};
      end
      p = 2 * l - q;
      if (p < 0) p = 0;
      return {channel_byte(p, q, h6 + 2 * ONE), channel_byte(p, q, h6),
              channel_byte(p, q, h6 - 2 * ONE)};
    endfunction

    function void note_hsl(logic act, logic [FRAC:0] hue_in, logic [FRAC:0] light_in);
      pending_rgb = {pending_rgb, predict_rgb(act, hue_in, light_in)};
    endfunction

    function void check_rgb(logic [23:0] got);
      logic [23:0] want;
      if (pending_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected rgb_color transaction, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_rgb.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: rgb_color mismatch, expected %h, actual %h", $time, want, got);
      end
    endfunction
  endclass

  logic          clk          = 1'b0;
  logic          rst_n        = 1'b0;
  logic          in_valid     = 1'b0;
  logic          in_stall;
  logic          in_action    = 1'b0;
  logic [FRAC:0] in_hue       = '0;
  logic [FRAC:0] in_lightness = '0;
  logic          out_valid;
  logic          out_stall    = 1'b0;
  logic [23:0]   out_rgb_color;
  logic          cfg_wr_en    = 1'b0;
  logic [FRAC:0] cfg_wr_data  = '0;
  bit            idle_on      = 1'b1;

  rgb_scoreboard sb = new();

  hsl_to_rgb_converter #(.FRAC_BITS(FRAC)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_hue       (in_hue),
    .in_lightness (in_lightness),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rgb_color(out_rgb_color),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Send one transaction, with an optional idle gap ahead of it
  task automatic send_hsl(logic act, logic [FRAC:0] hue_v, logic [FRAC:0] light_v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_hue       <= hue_v;
    in_lightness <= light_v;
    do @(posedge clk); while (in_stall);
    sb.note_hsl(act, hue_v, light_v);
  endtask

  // Value biased toward the unit-range edges and segment boundaries, at times above one
  function automatic logic [FRAC:0] rand_unit();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, (1 << (FRAC + 1)) - 1);
      1:       v = int'(ONE);
      2:       v = 0;
      3: begin
        v = ($urandom_range(0, 12) * int'(ONE)) / 12 + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
      end
      default: v = $urandom_range(0, int'(ONE));
    endcase
    return v[FRAC:0];
  endfunction

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) send_hsl(1'($urandom_range(0, 1)), rand_unit(), rand_unit());
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_saturation(logic [FRAC:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.sat = v;
  endtask

  // Result side stall bursts
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_rgb(out_rgb_color);
  end

  // Main sequence
  initial begin
    logic [FRAC:0] sat_list[7];
    sat_list = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd0, 17'd0, 17'd32768};
    sat_list[4] = (FRAC+1)'($urandom_range(0, int'(ONE)));
    sat_list[5] = (FRAC+1)'($urandom_range(0, (1 << (FRAC + 1)) - 1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both modes, corrector index and segment boundaries
    send_hsl(1'b0, 17'd0,      17'd0);
    send_hsl(1'b1, 17'd0,      17'd0);
    send_hsl(1'b0, 17'd65536,  17'd65536);
    send_hsl(1'b1, 17'd65536,  17'd65536);
    send_hsl(1'b0, 17'd131071, 17'd131071);
    send_hsl(1'b1, 17'd131071, 17'd0);
    send_hsl(1'b0, 17'd0,      17'd32767);
    send_hsl(1'b0, 17'd0,      17'd32768);
    send_hsl(1'b1, 17'd5461,   17'd20000);
    send_hsl(1'b1, 17'd5462,   17'd20000);
    send_hsl(1'b1, 17'd16384,  17'd40000);
    send_hsl(1'b1, 17'd49151,  17'd30000);
    send_hsl(1'b1, 17'd60074,  17'd30000);
    send_hsl(1'b1, 17'd60075,  17'd30000);
    send_hsl(1'b0, 17'd10923,  17'd50000);
    send_hsl(1'b0, 17'd21845,  17'd50000);
    send_hsl(1'b0, 17'd43690,  17'd50000);
    send_hsl(1'b0, 17'd32768,  17'd65535);
    send_hsl(1'b0, 17'd1,      17'd1);
    send_hsl(1'b1, 17'd65535,  17'd65535);
    send_hsl(1'b1, 17'd87381,  17'd98304);
    in_valid <= 1'b0;
    wait_drained();

    // random phases across saturation settings; last one without idling
    foreach (sat_list[i]) begin
      if (i == 6) idle_on = 1'b0;
      write_saturation(sat_list[i]);
      run_phase(N_PHASE);
      wait_drained();
    end

    repeat (LATENCY * 2) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rgb.size() == 0) begin
      $display("PASS hsl_to_rgb_converter");
    end else begin
      $display("FAIL hsl_to_rgb_converter");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL hsl_to_rgb_converter");
    $finish;
  end

endmodule

`default_nettype wire
